[design/cbas_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and the pin pair table for the charlieplex scanner.
// No dependencies.
package cbas_pkg;

   localparam int LED_COUNT_DEF  = 12;
   localparam int BIT_PHASES_DEF = 3;

   localparam logic       MODE_EVENT = 1'b0;
   localparam logic       MODE_WRITE = 1'b1;

   localparam logic [1:0] REG_SLOT0 = 2'd0;
   localparam logic [1:0] REG_SLOT1 = 2'd1;
   localparam logic [1:0] REG_SLOT2 = 2'd2;
   localparam logic [1:0] REG_TICK  = 2'd3;

   localparam logic [7:0] SLOT0_RST = 8'd2;
   localparam logic [7:0] SLOT1_RST = 8'd8;
   localparam logic [7:0] SLOT2_RST = 8'd16;
   localparam logic [7:0] TICK_RST  = 8'd72;

   localparam logic [4:0] PIN_MASK   = 5'h1D;
   localparam int         ENTRY_W    = 4;   // bits 2:0 brightness, bit 3 keep flag
   localparam int         KEEP_IN    = 7;   // keep flag position in the write word

   typedef struct packed {
      logic [2:0][7:0] slot_time;
      logic [7:0]      tick_period;
   } cbas_cfg_type;

   // one-hot pin for each LED slot of the pin pair table
   function automatic logic [4:0] pin_at(input logic [3:0] idx);
      logic [4:0] p;
      case (idx)
         4'd0:    p = 5'h01;
         4'd1:    p = 5'h04;
         4'd2:    p = 5'h04;
         4'd3:    p = 5'h08;
         4'd4:    p = 5'h08;
         4'd5:    p = 5'h10;
         4'd6:    p = 5'h01;
         4'd7:    p = 5'h08;
         4'd8:    p = 5'h04;
         4'd9:    p = 5'h10;
         4'd10:   p = 5'h01;
         4'd11:   p = 5'h10;
         default: p = 5'h00;
      endcase
      return p;
   endfunction

endpackage

[design/cbas_if.sv]
`timescale 1ns / 1ps
// Channel interfaces: request, response and register write.
// Standalone; widths follow the block's fixed field widths.
interface cbas_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [3:0] led_select;
   logic [7:0] led_value;
   modport source (output valid, mode, led_select, led_value, input ready);
   modport sink   (input valid, mode, led_select, led_value, output ready);
endinterface

interface cbas_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] pin_direction;
   logic [4:0] pin_level;
   logic [7:0] slot_time;
   logic [3:0] lit_index;
   logic       lit;
   logic       tick;
   modport source (output valid, pin_direction, pin_level, slot_time, lit_index, lit, tick,
                   input ready);
   modport sink   (input valid, pin_direction, pin_level, slot_time, lit_index, lit, tick,
                   output ready);
endinterface

interface cbas_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/cbas_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cbas_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 12
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[design/cbas_csr.sv]
`timescale 1ns / 1ps
// Configuration registers: slot compare values and tick period.
// Uses cbas_pkg and cbas_csr_if.
module cbas_csr
   import cbas_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   cbas_csr_if.sink         csr,
   output cbas_cfg_type     cfg
);
   cbas_cfg_type cfg_ff, cfg_in;

   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            REG_SLOT0: cfg_in.slot_time[0] = csr.data;
            REG_SLOT1: cfg_in.slot_time[1] = csr.data;
            REG_SLOT2: cfg_in.slot_time[2] = csr.data;
            REG_TICK:  cfg_in.tick_period  = csr.data;
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slot_time[0] <= SLOT0_RST;
         cfg_ff.slot_time[1] <= SLOT1_RST;
         cfg_ff.slot_time[2] <= SLOT2_RST;
         cfg_ff.tick_period  <= TICK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

[design/cbas_seq.sv]
`timescale 1ns / 1ps
// Scan sequencer: serves one slot event, then walks the store for the next LED.
// Uses cbas_pkg, cbas_req_if and cbas_rsp_if; drives the brightness RAM ports.
module cbas_seq
   import cbas_pkg::*;
#(
   parameter int LED_COUNT  = LED_COUNT_DEF,
   parameter int BIT_PHASES = BIT_PHASES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   cbas_req_if.sink                     req,
   cbas_rsp_if.source                   rsp,
   input  cbas_cfg_type                 cfg,
   output logic                         wr_en,
   output logic [$clog2(LED_COUNT)-1:0] wr_addr,
   output logic [ENTRY_W-1:0]           wr_data,
   output logic [$clog2(LED_COUNT)-1:0] rd_addr,
   input  logic [ENTRY_W-1:0]           rd_data
);
   localparam int AW = $clog2(LED_COUNT);
   localparam int SW = $clog2(LED_COUNT + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EVENT = 2'd1;   // entry of served LED on rd_data
   localparam logic [1:0] S_SEEK  = 2'd2;   // entry of candidate LED on rd_data

   logic [1:0]           state_ff, state_in;
   logic [AW-1:0]        scan_ff, scan_in, scan_nxt;
   logic [1:0]           phase_ff, phase_in, phase_nxt;
   logic [7:0]           count_ff, count_in;
   logic [SW-1:0]        step_ff, step_in;
   logic [LED_COUNT-1:0] valid_ff, valid_in;

   logic                 out_vld_ff, out_vld_in;
   logic [4:0]           dir_ff, dir_in, lvl_ff, lvl_in;
   logic [7:0]           slot_ff, slot_in;
   logic [3:0]           idx_ff, idx_in;
   logic                 lit_ff, lit_in, tick_ff, tick_in;

   logic                 accept, out_free, tick_hit, lit_now;
   logic [ENTRY_W-1:0]   entry;
   logic [3:0]           scan_w;
   logic [7:0]           slot_sel;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign out_free  = !out_vld_ff || rsp.ready;

   // entries never written read as zero
   assign entry   = valid_ff[scan_ff] ? rd_data : '0;
   assign scan_w  = 4'(scan_ff);
   assign lit_now = entry[phase_ff];
   assign tick_hit = ({1'b0, count_ff} + 9'd1) >= {1'b0, cfg.tick_period};

   assign scan_nxt  = (scan_ff == AW'(LED_COUNT - 1)) ? '0 : scan_ff + AW'(1);
   assign phase_nxt = (scan_nxt != '0) ? phase_ff :
                      (phase_ff == 2'(BIT_PHASES - 1)) ? 2'd0 : phase_ff + 2'd1;

   always_comb begin
      case (phase_ff)
         2'd0:    slot_sel = cfg.slot_time[0];
         2'd1:    slot_sel = cfg.slot_time[1];
         default: slot_sel = cfg.slot_time[2];
      endcase
   end

   assign wr_en   = accept && (req.mode == MODE_WRITE) && (req.led_select < 4'(LED_COUNT));
   assign wr_addr = req.led_select[AW-1:0];
   assign wr_data = {req.led_value[KEEP_IN], req.led_value[2:0]};

   always_comb begin
      state_in   = state_ff;
      scan_in    = scan_ff;
      phase_in   = phase_ff;
      count_in   = count_ff;
      step_in    = step_ff;
      valid_in   = valid_ff;
      rd_addr    = scan_ff;
      out_vld_in = out_vld_ff && !rsp.ready;
      dir_in     = dir_ff;
      lvl_in     = lvl_ff;
      slot_in    = slot_ff;
      idx_in     = idx_ff;
      lit_in     = lit_ff;
      tick_in    = tick_ff;

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept && req.mode == MODE_EVENT) begin
               state_in = S_EVENT;
            end
         end
         S_EVENT: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               lit_in     = lit_now;
               dir_in     = lit_now ? ((pin_at(scan_w | 4'd1) | pin_at(scan_w & ~4'd1))
                                       & PIN_MASK) : 5'd0;
               lvl_in     = lit_now ? (pin_at(scan_w) & PIN_MASK) : 5'd0;
               slot_in    = slot_sel;
               idx_in     = scan_w;
               tick_in    = tick_hit;
               count_in   = tick_hit ? 8'd0 : count_ff + 8'd1;
               scan_in    = scan_nxt;
               phase_in   = phase_nxt;
               rd_addr    = scan_nxt;
               step_in    = '0;
               state_in   = S_SEEK;
            end
         end
         S_SEEK: begin
            if (entry != '0 || step_ff >= SW'(LED_COUNT)) begin
               state_in = S_IDLE;
            end else begin
               step_in  = step_ff + SW'(1);
               scan_in  = scan_nxt;
               phase_in = phase_nxt;
               rd_addr  = scan_nxt;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         scan_ff    <= '0;
         phase_ff   <= 2'd0;
         count_ff   <= 8'd0;
         step_ff    <= '0;
         valid_ff   <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         scan_ff    <= scan_in;
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         step_ff    <= step_in;
         valid_ff   <= valid_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff  <= dir_in;
      lvl_ff  <= lvl_in;
      slot_ff <= slot_in;
      idx_ff  <= idx_in;
      lit_ff  <= lit_in;
      tick_ff <= tick_in;
   end

   assign rsp.valid         = out_vld_ff;
   assign rsp.pin_direction = dir_ff;
   assign rsp.pin_level     = lvl_ff;
   assign rsp.slot_time     = slot_ff;
   assign rsp.lit_index     = idx_ff;
   assign rsp.lit           = lit_ff;
   assign rsp.tick          = tick_ff;
endmodule

[design/charlieplex_bit_angle_scanner.sv]
`timescale 1ns / 1ps
// Top level of the charlieplexed LED bit-angle scanner.
// Uses cbas_pkg, the channel interfaces, cbas_csr, cbas_seq and cbas_ram.
//
//  port     dir    word
//  req_if   in     mode, led_select, led_value
//  rsp_if   out    pin_direction, pin_level, slot_time, lit_index, lit, tick
//  csr_if   in     index, data (always ready)
//
// A slot event does one RAM read for the served LED, then one RAM read per step of the
// skip search.
// Reset clears the scan position, phase, tick counter and the per-LED valid bits,
// so the store reads as all dark without a clearing pass.
// The result waits in an output register; a stalled response holds the event.
module charlieplex_bit_angle_scanner
   import cbas_pkg::*;
#(
   parameter int LED_COUNT  = LED_COUNT_DEF,
   parameter int BIT_PHASES = BIT_PHASES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   cbas_req_if.sink    req_if,
   cbas_rsp_if.source  rsp_if,
   cbas_csr_if.sink    csr_if
);
   localparam int AW = $clog2(LED_COUNT);

   cbas_cfg_type       cfg;
   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;

   cbas_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_if),
      .cfg   (cfg)
   );

   cbas_seq #(
      .LED_COUNT  (LED_COUNT),
      .BIT_PHASES (BIT_PHASES)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .cfg     (cfg),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cbas_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LED_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );
endmodule
